### rtl/bma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bma_pkg: shared types and codes of the BCD mantissa ALU
// Holds the operation codes and the control bundle that travels along the
// row of digit cells.
// ----------------------------------------------------------------------------
package bma_pkg;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_INC = 3'd2;
	localparam logic [2:0] OP_DEC = 3'd3;
	localparam logic [2:0] OP_SHL = 3'd4;
	localparam logic [2:0] OP_SHR = 3'd5;
	localparam logic [2:0] OP_CMP = 3'd6;

	localparam logic signed [1:0] ORD_LT = 2'sb11;
	localparam logic signed [1:0] ORD_EQ = 2'sb00;
	localparam logic signed [1:0] ORD_GT = 2'sb01;

	// Control that moves from one digit cell to the next with each beat.
	typedef struct packed {
		logic              valid;
		logic [2:0]        op;
		logic              flag;   // carry, borrow or sticky so far
		logic signed [1:0] ord;    // compare of the digits seen so far
		logic              nz;     // some digit of a seen so far is nonzero
	} bma_ctl_t;

endpackage

### rtl/bcd_mantissa_alu_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_mantissa_alu_top: packed BCD mantissa add, subtract, step, shift, compare
// Row of digit cells, one per BCD digit, forming a pipelined decimal chain.
// ----------------------------------------------------------------------------
// The unit takes one beat per clock cycle unless the output side stalls, and
// returns one beat per input beat, in order. Each beat travels through a row
// of DIGITS cells, one cell for each BCD digit starting from the least
// significant one, and is registered in each cell. The carry, borrow, compare
// and zero chains each move one digit per cycle inside this row while it
// advances. The whole row advances whenever the output register is empty or
// being taken, so s_tready follows m_tready directly and a full pipeline keeps
// flowing while the output side takes one beat per cycle.
//
// Input beat: s_tuser holds req_type (0 add, 1 subtract, 2 increment,
// 3 decrement, 4 shift left one digit, 5 shift right one digit, 6 or 7
// compare only). s_tdata holds operand_a, operand_b and borrow_in.
// Output beat: m_tdata holds digits_out, flag_out, order (signed, -1 less,
// 0 equal, +1 greater) and a_is_zero. Operands are taken as valid BCD.
module bcd_mantissa_alu_top import bma_pkg::*; #(
	parameter int DIGITS = 14
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// [W-1:0] operand_a, [2W-1:W] operand_b, [2W] borrow_in, zero fill
	input  logic [((2*DIGITS*4+1+7)/8)*8-1:0] s_tdata,
	// [2:0] req_type
	input  logic [2:0] s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// [W-1:0] digits_out, [W] flag_out, [W+2:W+1] order, [W+3] a_is_zero,
	// zero fill
	output logic [((DIGITS*4+4+7)/8)*8-1:0] m_tdata
);

	localparam int W     = DIGITS * 4;
	localparam int OUT_W = ((W + 4 + 7) / 8) * 8;

	bma_ctl_t         ctl_w [DIGITS+1];
	logic [W-1:0]     a_w   [DIGITS+1];
	logic [W-1:0]     b_w   [DIGITS+1];
	logic [W-1:0]     r_w   [DIGITS+1];
	logic             adv;
	logic             flag0;

	// The row moves as a whole; the last cell is the output register.
	assign adv      = !ctl_w[DIGITS].valid || m_tready;
	assign s_tready = adv;

	// Initial carry or borrow entering the lowest digit.
	always_comb begin
		case (s_tuser)
			OP_SUB:         flag0 = s_tdata[2*W];
			OP_INC, OP_DEC: flag0 = 1'b1;
			default:        flag0 = 1'b0;
		endcase
	end

	always_comb begin
		ctl_w[0].valid = s_tvalid;
		ctl_w[0].op    = s_tuser;
		ctl_w[0].flag  = flag0;
		ctl_w[0].ord   = ORD_EQ;
		ctl_w[0].nz    = 1'b0;
	end

	assign a_w[0] = s_tdata[W-1:0];
	assign b_w[0] = s_tdata[2*W-1:W];
	assign r_w[0] = s_tdata[W-1:0];

	generate
		for (genvar k = 0; k < DIGITS; k++) begin : g_cell
			bma_cell #(
				.DIGITS(DIGITS),
				.POS   (k)
			) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (adv),
				.ctl_in (ctl_w[k]),
				.a_in   (a_w[k]),
				.b_in   (b_w[k]),
				.r_in   (r_w[k]),
				.ctl_out(ctl_w[k+1]),
				.a_out  (a_w[k+1]),
				.b_out  (b_w[k+1]),
				.r_out  (r_w[k+1])
			);
		end
	endgenerate

	assign m_tvalid = ctl_w[DIGITS].valid;
	assign m_tdata  = OUT_W'({!ctl_w[DIGITS].nz, ctl_w[DIGITS].ord,
		ctl_w[DIGITS].flag, r_w[DIGITS]});

endmodule

### rtl/bma_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bma_cell: one digit position of the BCD mantissa ALU
// Works on digit POS of the operands, folds it into the carry, compare and
// zero chains, and registers everything for the next cell.
// ----------------------------------------------------------------------------
module bma_cell import bma_pkg::*; #(
	parameter int DIGITS = 14,
	parameter int POS    = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  bma_ctl_t              ctl_in,
	input  logic [DIGITS*4-1:0]   a_in,
	input  logic [DIGITS*4-1:0]   b_in,
	input  logic [DIGITS*4-1:0]   r_in,
	output bma_ctl_t              ctl_out,
	output logic [DIGITS*4-1:0]   a_out,
	output logic [DIGITS*4-1:0]   b_out,
	output logic [DIGITS*4-1:0]   r_out
);

	logic [3:0] ai, bi, bx, alo, ahi, dig;
	logic [4:0] sum5, sum_adj;
	logic [5:0] diff6;
	logic       fl;
	logic signed [1:0] ord_n;
	logic [DIGITS*4-1:0] r_n;
	logic       ctl_valid_q;
	bma_ctl_t   ctl_pay_q;

	assign ai = a_in[POS*4 +: 4];
	assign bi = b_in[POS*4 +: 4];

	generate
		if (POS > 0) begin : g_lo
			assign alo = a_in[(POS-1)*4 +: 4];
		end else begin : g_lo0
			assign alo = 4'd0;
		end
		if (POS < DIGITS-1) begin : g_hi
			assign ahi = a_in[(POS+1)*4 +: 4];
		end else begin : g_hi0
			assign ahi = 4'd0;
		end
	endgenerate

	always_comb begin
		bx      = (ctl_in.op == OP_INC || ctl_in.op == OP_DEC) ? 4'd0 : bi;
		sum5    = {1'b0, ai} + {1'b0, bx} + {4'd0, ctl_in.flag};
		sum_adj = sum5 - 5'd10;
		diff6   = {2'b00, ai} - {2'b00, bx} - {5'd0, ctl_in.flag};
		case (ctl_in.op)
			OP_ADD, OP_INC: begin
				fl  = (sum5 >= 5'd10);
				dig = fl ? sum_adj[3:0] : sum5[3:0];
			end
			OP_SUB, OP_DEC: begin
				fl  = diff6[5];
				dig = fl ? (diff6[3:0] + 4'd10) : diff6[3:0];
			end
			OP_SHL: begin
				fl  = 1'b0;
				dig = alo;
			end
			OP_SHR: begin
				// The digit falling off sits in the lowest cell.
				fl  = (POS == 0) ? (ai != 4'd0) : ctl_in.flag;
				dig = ahi;
			end
			default: begin
				fl  = 1'b0;
				dig = ai;
			end
		endcase

		// Digits arrive least significant first, so a higher digit that
		// differs overrides whatever the lower ones decided.
		if (ai > bi)      ord_n = ORD_GT;
		else if (ai < bi) ord_n = ORD_LT;
		else              ord_n = ctl_in.ord;

		r_n = r_in;
		r_n[POS*4 +: 4] = dig;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_valid_q <= 1'b0;
		end else if (en) begin
			ctl_valid_q <= ctl_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_pay_q.valid <= ctl_in.valid;
			ctl_pay_q.op    <= ctl_in.op;
			ctl_pay_q.flag  <= fl;
			ctl_pay_q.ord   <= ord_n;
			ctl_pay_q.nz    <= ctl_in.nz | (ai != 4'd0);
			a_out           <= a_in;
			b_out           <= b_in;
			r_out           <= r_n;
		end
	end

	always_comb begin
		ctl_out       = ctl_pay_q;
		ctl_out.valid = ctl_valid_q;
	end

endmodule

### rtl/bma_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bma_checker: port-level checks for the BCD mantissa ALU
// Watches the stream ports of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module bma_checker #(
	parameter int DIGITS = 14
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic [((2*DIGITS*4+1+7)/8)*8-1:0] s_tdata,
	input logic [2:0] s_tuser,
	input logic m_tvalid,
	input logic m_tready,
	input logic [((DIGITS*4+4+7)/8)*8-1:0] m_tdata
);

	localparam int W = DIGITS * 4;

	// A stalled output beat stays in place.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output beat changed while stalled");

	// The input side moves exactly when the output register can move.
	a_ready_link: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("s_tready does not follow the output side");

	// The compare result is never the unused code.
	a_order_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[W+2:W+1] != 2'b10)
		else $error("order holds an undefined code");

	// A zero operand a cannot compare greater than b.
	a_zero_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[W+3] |-> m_tdata[W+2:W+1] != 2'b01)
		else $error("zero operand reported greater");

endmodule

bind bcd_mantissa_alu_top bma_checker #(.DIGITS(DIGITS)) u_bma_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tdata (s_tdata),
	.s_tuser (s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
